[rtl/core/fecp_pkg.sv]
// Shared constants and types for the flash erase command planner.
`timescale 1ns / 1ps

package fecp_pkg;

    // Field widths
    localparam int ADDR_W   = 24;
    localparam int CHIP_W   = 22;
    localparam int CMD_W    = 8;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = ADDR_W + 1;

    // Erase unit sizes in bytes
    localparam int SECTOR_BYTES     = 4096;
    localparam int HALF_BLOCK_BYTES = 32768;
    localparam int FULL_BLOCK_BYTES = 65536;

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int HALF_SHIFT   = $clog2(HALF_BLOCK_BYTES);
    localparam int FULL_SHIFT   = $clog2(FULL_BLOCK_BYTES);

    // Longest command list for one request
    localparam int MAX_CMDS = 64;

    localparam logic [CHIP_W-1:0] CHIP_BYTES_RESET = CHIP_W'(1048576);

    // Flash opcodes
    localparam logic [CMD_W-1:0] OP_NONE   = 8'h00;
    localparam logic [CMD_W-1:0] OP_FULL   = 8'hD8;
    localparam logic [CMD_W-1:0] OP_HALF   = 8'h52;
    localparam logic [CMD_W-1:0] OP_SECTOR = 8'h20;
    localparam logic [CMD_W-1:0] OP_CHIP   = 8'hC7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALIGN = 2'd2;

    typedef enum logic
    {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Request to the shared adder
    typedef struct packed
    {
        alu_op_t          op;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } alu_req_t;

endpackage

[rtl/core/fecp_addsub.sv]
// Shared add and subtract unit of the erase planner sequencer.
`timescale 1ns / 1ps

module fecp_addsub (
    input  fecp_pkg::alu_req_t           req,
    output logic [fecp_pkg::SUM_W:0]     result
);
    import fecp_pkg::*;

    logic [SUM_W:0] a_ext;
    logic [SUM_W:0] b_ext;

    assign a_ext = {1'b0, req.a};
    assign b_ext = {1'b0, req.b};

    // For a subtraction the top bit is set exactly when a is below b.
    always_comb
    begin
        case (req.op)
            ALU_ADD: result = a_ext + b_ext;
            ALU_SUB: result = a_ext - b_ext;
            default: result = a_ext + b_ext;
        endcase
    end

endmodule

[rtl/core/flash_erase_command_planner_core.sv]
// Top level of the flash erase command planner: sequencer, registers and stream ports.
`timescale 1ns / 1ps

// The planner takes one erase request item (start offset and length) and answers with
// the ordered list of flash erase command items. A request that runs past the end of
// the chip, or whose offset or length is not a multiple of the sector size, gives one
// status item; a request whose length equals the chip size gives one chip-erase item;
// an empty request gives one status item with status ok. Otherwise the region is walked
// from its start, taking at each step the largest of full block, half block or sector
// that is aligned at the current address and fits in what remains; the list stops after
// MAX_CMDS commands. Sequencing: one adder is shared by every step, so an accepted
// request first goes through checking (range sum, then compare against the chip size)
// and then, for each erase command, through an address advance and then a length
// decrement, the last command needing only the first of them. A status or chip-erase
// item goes out once the checks are done. The sequencer waits in its output steps
// while the output register is not taken. The block takes a new request only when its
// sequencer is idle; the last result may still be waiting in the output register at that
// time. The chip size register is written through the configuration channel; the user
// must do so only while no request is in progress. The block itself does not enforce it.

module flash_erase_command_planner_core #(
    parameter int MAX_CMDS = fecp_pkg::MAX_CMDS
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // Configuration: chip size in bytes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fecp_pkg::CHIP_W-1:0] cfg_data,

    // Request items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,   // [23:0] start_offset, [47:24] erase_length

    // Command items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [7:0] command_byte, [31:8] target_address
    output logic [2:0]                  m_tuser,   // [0] has_command, [2:1] status
    output logic                        m_tlast    // last result of the request
);
    import fecp_pkg::*;

    localparam int CNT_W = (MAX_CMDS > 1) ? $clog2(MAX_CMDS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CMDS - 1);

    // One-hot sequencer states
    typedef enum logic [5:0]
    {
        S_IDLE   = 6'b000001,
        S_SUM    = 6'b000010,
        S_CHECK  = 6'b000100,
        S_RESULT = 6'b001000,
        S_STEP   = 6'b010000,
        S_DEC    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CHIP_W-1:0]   chip_reg;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   left_reg, left_next;
    logic [ADDR_W-1:0]   size_reg, size_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Single status or chip-erase result waiting for the output register
    logic [CMD_W-1:0]    res_cmd_reg, res_cmd_next;
    logic                res_has_reg, res_has_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]    out_cmd_reg, out_cmd_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic                out_has_reg, out_has_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    alu_req_t            alu_req;
    logic [SUM_W:0]      alu_result;

    logic                slot_free;
    logic [ADDR_W-1:0]   step_size;
    logic [CMD_W-1:0]    step_cmd;
    logic                step_last;

    fecp_addsub u_addsub (
        .req    (alu_req),
        .result (alu_result)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || m_tready;

    // Largest unit aligned at the current address that still fits in the remainder.
    // The offset is already sector aligned, so the sector is always the fallback.
    always_comb
    begin
        if ((addr_reg[FULL_SHIFT-1:0] == '0) && (left_reg[ADDR_W-1:FULL_SHIFT] != '0))
        begin
            step_size = ADDR_W'(FULL_BLOCK_BYTES);
            step_cmd  = OP_FULL;
        end
        else if ((addr_reg[HALF_SHIFT-1:0] == '0) && (left_reg[ADDR_W-1:HALF_SHIFT] != '0))
        begin
            step_size = ADDR_W'(HALF_BLOCK_BYTES);
            step_cmd  = OP_HALF;
        end
        else
        begin
            step_size = ADDR_W'(SECTOR_BYTES);
            step_cmd  = OP_SECTOR;
        end
    end

    // The list ends when the remainder is used up or the command limit is reached.
    assign step_last = (left_reg == step_size) || (cnt_reg == CNT_LAST);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, addr_reg};
        alu_req.b  = {1'b0, left_reg};
        case (state_reg)
            S_CHECK:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = SUM_W'(chip_reg);
                alu_req.b  = sum_reg;
            end
            S_STEP:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {1'b0, addr_reg};
                alu_req.b  = {1'b0, step_size};
            end
            S_DEC:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {1'b0, left_reg};
                alu_req.b  = {1'b0, size_reg};
            end
            default:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {1'b0, addr_reg};
                alu_req.b  = {1'b0, left_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        left_next       = left_reg;
        size_next       = size_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        res_cmd_next    = res_cmd_reg;
        res_has_next    = res_has_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cmd_next    = out_cmd_reg;
        out_addr_next   = out_addr_reg;
        out_has_next    = out_has_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next  = s_tdata[ADDR_W-1:0];
                    left_next  = s_tdata[2*ADDR_W-1:ADDR_W];
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                sum_next   = alu_result[SUM_W-1:0];
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                // Checks in priority order: range, alignment, whole chip, empty.
                state_next      = S_RESULT;
                res_cmd_next    = OP_NONE;
                res_has_next    = 1'b0;
                res_status_next = ST_OK;
                cnt_next        = '0;
                if (alu_result[SUM_W])
                begin
                    res_status_next = ST_RANGE;
                end
                else if ((addr_reg[SECTOR_SHIFT-1:0] != '0)
                         || (left_reg[SECTOR_SHIFT-1:0] != '0))
                begin
                    res_status_next = ST_ALIGN;
                end
                else if (left_reg == ADDR_W'(chip_reg))
                begin
                    res_cmd_next = OP_CHIP;
                    res_has_next = 1'b1;
                end
                else if (left_reg != '0)
                begin
                    state_next = S_STEP;
                end
            end

            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_cmd_next    = res_cmd_reg;
                    out_addr_next   = '0;
                    out_has_next    = res_has_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_STEP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_cmd_next    = step_cmd;
                    out_addr_next   = addr_reg;
                    out_has_next    = 1'b1;
                    out_status_next = ST_OK;
                    out_last_next   = step_last;
                    addr_next       = alu_result[ADDR_W-1:0];
                    size_next       = step_size;
                    state_next      = step_last ? S_IDLE : S_DEC;
                end
            end

            S_DEC:
            begin
                left_next  = alu_result[ADDR_W-1:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_STEP;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            chip_reg      <= CHIP_BYTES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                chip_reg <= cfg_data;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        left_reg       <= left_next;
        size_reg       <= size_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        res_cmd_reg    <= res_cmd_next;
        res_has_reg    <= res_has_next;
        res_status_reg <= res_status_next;
        out_cmd_reg    <= out_cmd_next;
        out_addr_reg   <= out_addr_next;
        out_has_reg    <= out_has_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_addr_reg, out_cmd_reg};
    assign m_tuser  = {out_status_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule

[dv/tb_flash_erase_command_planner_core.sv]
// Self-checking testbench for the flash erase command planner core.
`timescale 1ns / 1ps

// Each erase request item goes into a predictor that works out the expected command items
// using the chip size that the testbench last wrote. The monitor compares every command item
// that the block hands over, field by field, with the oldest expectation. A directed part covers
// the field extremes and each special case: empty, whole chip, out of range, misaligned, the
// request ending exactly at the end of the chip, and the list cut short at the command limit.
// After that, random phases run, each with its own chip size. The sender works in bursts with
// gaps between them. The receiver switches between several stall patterns, so both sides idle
// during every stage of the block's work.

module tb_flash_erase_command_planner_core;

    import fecp_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int MAX_PRINTED    = 50;

    // One expected command item.
    typedef struct packed
    {
        logic [CMD_W-1:0]    opcode;
        logic [ADDR_W-1:0]   address;
        logic                has_cmd;
        logic [STATUS_W-1:0] status;
        logic                is_last;
    } erase_cmd_t;

    // Stall patterns of the command receiver.
    typedef enum logic [1:0]
    {
        RDY_ALWAYS = 2'd0,
        RDY_COIN   = 2'd1,
        RDY_EVERY4 = 2'd2,
        RDY_BURSTY = 2'd3
    } ready_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CHIP_W-1:0]   cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;
    logic [2:0]          m_tuser;
    logic                m_tlast;

    // Requests waiting to be offered, each packed as {erase_length, start_offset}.
    logic [47:0]         erase_requests[$];
    // Command items that the block still owes.
    erase_cmd_t          expected_cmds[$];
    // The testbench's own copy of the chip size register.
    logic [CHIP_W-1:0]   flash_bytes = CHIP_BYTES_RESET;

    int                  mismatch_cnt = 0;
    int                  quiet_cycles = 0;

    flash_erase_command_planner_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic void push_status_only(input logic [STATUS_W-1:0] st);
        expected_cmds.push_back('{OP_NONE, '0, 1'b0, st, 1'b1});
    endfunction

    // Works out the command list for one request under the current chip size. The checks are
    // ordered as in the block: range first, then sector alignment, then whole chip, then empty.
    function automatic void plan_erase_commands(input logic [ADDR_W-1:0] offs,
                                                input logic [ADDR_W-1:0] len);
        logic [SUM_W-1:0]  span;
        logic [ADDR_W-1:0] cur;
        logic [ADDR_W-1:0] left;
        logic [ADDR_W-1:0] unit;
        logic [CMD_W-1:0]  op;
        int                n;
        span = {1'b0, offs} + {1'b0, len};
        if (span > SUM_W'(flash_bytes))
            push_status_only(ST_RANGE);
        else if ((offs % SECTOR_BYTES) != 0 || (len % SECTOR_BYTES) != 0)
            push_status_only(ST_ALIGN);
        else if (len == ADDR_W'(flash_bytes))
            expected_cmds.push_back('{OP_CHIP, '0, 1'b1, ST_OK, 1'b1});
        else if (len == '0)
            push_status_only(ST_OK);
        else
        begin
            cur  = offs;
            left = len;
            n    = 0;
            while (left != '0 && n < MAX_CMDS)
            begin
                // Largest unit that is aligned here and still fits in what remains.
                if (left >= FULL_BLOCK_BYTES && (cur % FULL_BLOCK_BYTES) == 0)
                begin
                    unit = ADDR_W'(FULL_BLOCK_BYTES);
                    op   = OP_FULL;
                end
                else if (left >= HALF_BLOCK_BYTES && (cur % HALF_BLOCK_BYTES) == 0)
                begin
                    unit = ADDR_W'(HALF_BLOCK_BYTES);
                    op   = OP_HALF;
                end
                else
                begin
                    unit = ADDR_W'(SECTOR_BYTES);
                    op   = OP_SECTOR;
                end
                expected_cmds.push_back('{op, cur, 1'b1, ST_OK, 1'b0});
                cur  = cur + unit;
                left = left - unit;
                n++;
            end
            expected_cmds[expected_cmds.size() - 1].is_last = 1'b1;
        end
    endfunction

    function automatic void add_request(input logic [ADDR_W-1:0] offs,
                                        input logic [ADDR_W-1:0] len);
        erase_requests.push_back({len, offs});
    endfunction

    // A random request under the current chip size. Most requests are well formed, sector
    // aligned and inside the chip, so that they reach the command walk; the rest are whole-chip
    // requests, random noise that is mostly out of range, and near misses on alignment.
    function automatic void add_random_request();
        int unsigned       n_sect;
        int unsigned       off_s;
        int unsigned       len_s;
        int unsigned       room;
        int unsigned       pick;
        logic [ADDR_W-1:0] offs;
        logic [ADDR_W-1:0] len;
        n_sect = flash_bytes / SECTOR_BYTES;
        pick   = $urandom_range(0, 99);
        off_s  = $urandom_range(0, n_sect);
        if ($urandom_range(0, 3) == 0)
            off_s = off_s & ~32'd15;
        room = n_sect - off_s;
        if ($urandom_range(0, 7) == 0)
            len_s = $urandom_range(0, room);
        else
            len_s = $urandom_range(0, (room < 40) ? room : 40);
        offs = ADDR_W'(off_s * SECTOR_BYTES);
        len  = ADDR_W'(len_s * SECTOR_BYTES);
        if (pick < 8)
        begin
            offs = '0;
            len  = ADDR_W'(flash_bytes);
        end
        else if (pick < 18)
        begin
            offs = ADDR_W'($urandom);
            len  = ADDR_W'($urandom);
        end
        else if (pick < 28)
        begin
            if ($urandom_range(0, 1) == 0)
                offs[11:0] = 12'($urandom_range(1, SECTOR_BYTES - 1));
            if ($urandom_range(0, 1) == 0 || offs[11:0] == '0)
                len[11:0] = 12'($urandom_range(1, SECTOR_BYTES - 1));
        end
        add_request(offs, len);
    endfunction

    // Returns at a rising edge once every queued request has been taken and every command item
    // has arrived. The state is looked at on the falling edge, when the driver's updates from
    // the rising edge have settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (erase_requests.size() != 0 || s_tvalid || expected_cmds.size() != 0);
        @(posedge clk);
    endtask

    // Writes the chip size register while the block is idle, and keeps the local copy in step.
    task automatic write_flash_bytes(input logic [CHIP_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        flash_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    // Request driver: offers queued items in bursts of random length, with random gaps of
    // idle cycles between bursts. The prediction is made at the edge that accepts an item.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        int unsigned burst_left;
        int unsigned gap_left;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                plan_erase_commands(s_tdata[23:0], s_tdata[47:24]);
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (erase_requests.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= erase_requests.pop_front();
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Command monitor and receiver: checks every accepted command item and drives tready
    // from a randomly chosen stall pattern that is changed now and then.
    always @(posedge clk or negedge rst_n)
    begin : command_monitor
        erase_cmd_t  want;
        ready_mode_t stall_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        logic        rdy;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_mode = RDY_ALWAYS;
            mode_left  = 0;
            hold_left  = 0;
            tick       = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cmds.size() == 0)
                    report_mismatch("command item with nothing expected", m_tdata, '0);
                else
                begin
                    want = expected_cmds.pop_front();
                    if (m_tdata[7:0] !== want.opcode)
                        report_mismatch("command_byte", 32'(m_tdata[7:0]), 32'(want.opcode));
                    if (m_tdata[31:8] !== want.address)
                        report_mismatch("target_address", 32'(m_tdata[31:8]),
                                        32'(want.address));
                    if (m_tuser[0] !== want.has_cmd)
                        report_mismatch("has_command", 32'(m_tuser[0]), 32'(want.has_cmd));
                    if (m_tuser[2:1] !== want.status)
                        report_mismatch("status", 32'(m_tuser[2:1]), 32'(want.status));
                    if (m_tlast !== want.is_last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
                end
            end

            if (mode_left == 0)
            begin
                stall_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                RDY_ALWAYS: rdy = 1'b1;
                RDY_COIN:   rdy = 1'($urandom_range(0, 1));
                RDY_EVERY4: rdy = (tick % 4 == 0);
                default:
                begin
                    // Long stalls now and then, otherwise ready.
                    if (hold_left != 0)
                    begin
                        hold_left--;
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            hold_left = $urandom_range(1, 24);
                    end
                end
            endcase
            m_tready <= rdy;
        end
    end

    // Watchdog: a hung handshake on any channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int                p;
        int                i;
        logic [CHIP_W-1:0] size_pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset chip size of 1 MiB.
        add_request(24'h000000, 24'h000000);    // empty request
        add_request(24'h000000, 24'h100000);    // whole chip
        add_request(24'h0FF000, 24'h001000);    // last sector of the chip
        add_request(24'h001000, 24'h001000);    // single sector
        add_request(24'h008000, 24'h008000);    // single half block
        add_request(24'h010000, 24'h010000);    // single full block
        add_request(24'h001000, 24'h01F000);    // sectors, half block, full block
        add_request(24'h003000, 24'h005000);    // sectors only, half block never fits
        add_request(24'h010000, 24'h018000);    // full block then half block
        add_request(24'h080000, 24'h080000);    // ends exactly at the end of the chip
        add_request(24'h001000, 24'h0FF000);    // ends at the end, not the whole chip
        add_request(24'h100000, 24'h000000);    // empty request right at the end
        add_request(24'h101000, 24'h000000);    // empty request past the end
        add_request(24'hFFF000, 24'h002000);    // runs past the end
        add_request(24'hFFFFFF, 24'hFFFFFF);    // both fields at their maximum
        add_request(24'h000001, 24'h001000);    // offset not sector aligned
        add_request(24'h001000, 24'h000FFF);    // length not sector aligned
        add_request(24'h000FFF, 24'h000001);    // both misaligned, inside the chip

        // Largest register value: not a sector multiple, long lists hit the command limit.
        write_flash_bytes(22'h3FFFFF);
        add_request(24'h001000, 24'h3FE000);    // cut after the command limit
        add_request(24'h000000, 24'h3FF000);    // also cut
        add_request(24'h000000, 24'h3FFFFF);    // whole chip but misaligned

        // Zero chip size: an empty request at offset zero counts as whole chip.
        write_flash_bytes(22'h000000);
        add_request(24'h000000, 24'h000000);
        add_request(24'h000000, 24'h001000);

        // Smallest and largest sizes in the stated range.
        write_flash_bytes(22'(SECTOR_BYTES));
        add_request(24'h000000, 24'h001000);
        add_request(24'h001000, 24'h000000);
        write_flash_bytes(22'h200000);
        add_request(24'h000000, 24'h200000);
        add_request(24'h001000, 24'h1FF000);

        // Random phases, each under its own chip size.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: size_pick = 22'(SECTOR_BYTES);
                1: size_pick = 22'h200000;
                2: size_pick = CHIP_BYTES_RESET;
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        size_pick = 22'($urandom);
                    else
                        size_pick = 22'($urandom_range(1, 512) * SECTOR_BYTES);
                end
            endcase
            write_flash_bytes(size_pick);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                add_random_request();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_cmds.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
